@@ design/lmbsd_pkg.sv @@
// ----------------------------------------------------------------------------
// lmbsd_pkg
// Shared types, codes and constants of the LED matrix scan driver.
// ----------------------------------------------------------------------------
package lmbsd_pkg;

   // Default geometry, handed to the top level as parameter defaults
   localparam int DEF_PANEL_COLUMNS  = 64;
   localparam int DEF_SCAN_ROW_PAIRS = 16;
   localparam int DEF_PLANE_COUNT    = 6;

   // Fixed field widths
   localparam int MODE_W       = 2;
   localparam int PIXEL_X_W    = 6;
   localparam int PIXEL_Y_W    = 5;
   localparam int LEVEL_W      = 8;
   localparam int RGB_W        = 3 * LEVEL_W;
   localparam int ROW_ADDR_W   = 5;
   localparam int BIT_SEL_W    = 3;
   localparam int BRIGHT_W     = 8;
   localparam int BASE_W       = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int REQ_DATA_W   = 40;
   localparam int RSP_DATA_W   = 16;

   // Register reset values
   localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 8'd255;
   localparam logic [BASE_W-1:0]   BASE_RESET   = 16'd250;

   // Exact unsigned division by 255 for dividends below 2**32
   localparam logic [31:0] DIV255_MAGIC = 32'h8080_8081;
   localparam int          DIV255_SHIFT = 39;

   // Cycles the lit-time pipeline needs after a register write
   localparam logic [1:0] SETTLE_CYCLES = 2'd2;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_CLEAR = 2'd2
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BRIGHTNESS = 2'd0,
      CSR_BASE_TICKS = 2'd1,
      CSR_SWAP_GB    = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_DATA   = 3'd0,
      PH_CLK_HI = 3'd1,
      PH_CLK_LO = 3'd2,
      PH_BLANK  = 3'd3,
      PH_LAT_HI = 3'd4,
      PH_LAT_LO = 3'd5,
      PH_LIT    = 3'd6
   } phase_type;

   // Pin controls of one tick, from the sequencer to the output stage
   typedef struct packed {
      logic                  data_en;
      logic                  shift_clock;
      logic                  latch;
      logic                  blank_n;
      logic                  frame_start;
      logic [ROW_ADDR_W-1:0] row_address;
      logic [BIT_SEL_W-1:0]  bit_sel;
   } scan_ctrl_type;

endpackage

@@ design/lmbsd_frame_store.sv @@
// ----------------------------------------------------------------------------
// lmbsd_frame_store
// Frame buffer split into upper and lower half memories, one read per half
// per tick, one pixel write, and a clearing sweep after reset and on clear.
// ----------------------------------------------------------------------------
module lmbsd_frame_store #(
   parameter int PANEL_COLUMNS  = lmbsd_pkg::DEF_PANEL_COLUMNS,
   parameter int SCAN_ROW_PAIRS = lmbsd_pkg::DEF_SCAN_ROW_PAIRS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              clear_start,
   input  logic                              rd_en,
   input  logic [$clog2(SCAN_ROW_PAIRS)-1:0] rd_row,
   input  logic [$clog2(PANEL_COLUMNS)-1:0]  rd_col,
   input  logic                              wr_en,
   input  logic [lmbsd_pkg::PIXEL_X_W-1:0]   wr_x,
   input  logic [lmbsd_pkg::PIXEL_Y_W-1:0]   wr_y,
   input  logic [lmbsd_pkg::RGB_W-1:0]       wr_rgb,
   output logic [lmbsd_pkg::RGB_W-1:0]       top_rgb,
   output logic [lmbsd_pkg::RGB_W-1:0]       bot_rgb,
   output logic                              busy
);

   localparam int HALF_DEPTH = PANEL_COLUMNS * SCAN_ROW_PAIRS;
   localparam int ADDR_W     = $clog2(HALF_DEPTH);
   localparam int COL_W      = $clog2(PANEL_COLUMNS);
   localparam int ROW_W      = $clog2(SCAN_ROW_PAIRS);
   localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(HALF_DEPTH - 1);
   localparam logic [lmbsd_pkg::PIXEL_Y_W-1:0] PIXEL_Y_OFS =
      lmbsd_pkg::PIXEL_Y_W'(SCAN_ROW_PAIRS);

   logic [lmbsd_pkg::RGB_W-1:0] mem_top [HALF_DEPTH];
   logic [lmbsd_pkg::RGB_W-1:0] mem_bot [HALF_DEPTH];

   logic [lmbsd_pkg::RGB_W-1:0] top_rd_ff, bot_rd_ff;
   logic                        busy_ff, busy_in;
   logic [ADDR_W-1:0]           sweep_ff, sweep_in;

   logic [ADDR_W-1:0]           rd_addr, wr_addr, mem_addr;
   logic [ROW_W-1:0]            wr_row;
   logic                        wr_in_panel, wr_top, wr_bot;
   logic                        we_top, we_bot;
   logic [lmbsd_pkg::RGB_W-1:0] mem_wdata;

   // Decode the pixel write into half and row
   always_comb begin
      wr_in_panel = (32'(wr_x) < 32'(PANEL_COLUMNS)) &&
                    (32'(wr_y) < 32'(2 * SCAN_ROW_PAIRS));
      wr_top      = wr_in_panel && (32'(wr_y) < 32'(SCAN_ROW_PAIRS));
      wr_bot      = wr_in_panel && !wr_top;
      wr_row      = wr_top ? ROW_W'(wr_y) : ROW_W'(wr_y - PIXEL_Y_OFS);
   end

   assign rd_addr = ADDR_W'(rd_row) * ADDR_W'(PANEL_COLUMNS) + ADDR_W'(rd_col);
   assign wr_addr = ADDR_W'(wr_row) * ADDR_W'(PANEL_COLUMNS) + ADDR_W'(COL_W'(wr_x));

   // Sweep owns the write port while clearing
   assign mem_addr  = busy_ff ? sweep_ff : wr_addr;
   assign mem_wdata = busy_ff ? '0 : wr_rgb;
   assign we_top    = busy_ff || (wr_en && wr_top);
   assign we_bot    = busy_ff || (wr_en && wr_bot);

   // Advance the clearing sweep
   always_comb begin
      busy_in  = busy_ff;
      sweep_in = sweep_ff;
      if (clear_start) begin
         busy_in  = 1'b1;
         sweep_in = '0;
      end else if (busy_ff) begin
         sweep_in = sweep_ff + 1'b1;
         if (sweep_ff == SWEEP_LAST) begin
            busy_in  = 1'b0;
            sweep_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         sweep_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         sweep_ff <= sweep_in;
      end
   end

   // Write ports
   always_ff @(posedge clock) begin
      if (we_top) begin
         mem_top[mem_addr] <= mem_wdata;
      end
      if (we_bot) begin
         mem_bot[mem_addr] <= mem_wdata;
      end
   end

   // Registered reads, held between ticks
   always_ff @(posedge clock) begin
      if (rd_en) begin
         top_rd_ff <= mem_top[rd_addr];
         bot_rd_ff <= mem_bot[rd_addr];
      end
   end

   assign top_rgb = top_rd_ff;
   assign bot_rgb = bot_rd_ff;
   assign busy    = busy_ff;

endmodule

@@ design/lmbsd_scan_seq.sv @@
// ----------------------------------------------------------------------------
// lmbsd_scan_seq
// Refresh sequencer: column shift, blank, latch and lit phases per row pair
// and bit plane, with a pipelined lit-time calculation from the registers.
// ----------------------------------------------------------------------------
module lmbsd_scan_seq #(
   parameter int PANEL_COLUMNS  = lmbsd_pkg::DEF_PANEL_COLUMNS,
   parameter int SCAN_ROW_PAIRS = lmbsd_pkg::DEF_SCAN_ROW_PAIRS,
   parameter int PLANE_COUNT    = lmbsd_pkg::DEF_PLANE_COUNT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [lmbsd_pkg::BRIGHT_W-1:0]    brightness,
   input  logic [lmbsd_pkg::BASE_W-1:0]      base_on_ticks,
   output logic [$clog2(SCAN_ROW_PAIRS)-1:0] cur_row,
   output logic [$clog2(PANEL_COLUMNS)-1:0]  cur_col,
   output lmbsd_pkg::scan_ctrl_type          ctrl
);

   localparam int COL_W   = $clog2(PANEL_COLUMNS);
   localparam int ROW_W   = $clog2(SCAN_ROW_PAIRS);
   localparam int PLANE_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
   localparam int PROD_W  = lmbsd_pkg::BASE_W + lmbsd_pkg::BRIGHT_W;
   localparam int NUM_W   = PROD_W + PLANE_COUNT - 1;
   localparam int LIT_W   = lmbsd_pkg::BASE_W + PLANE_COUNT - 1;
   localparam int BIT_BASE = 8 - PLANE_COUNT;

   localparam logic [COL_W-1:0]   COL_LAST   = COL_W'(PANEL_COLUMNS - 1);
   localparam logic [ROW_W-1:0]   ROW_LAST   = ROW_W'(SCAN_ROW_PAIRS - 1);
   localparam logic [PLANE_W-1:0] PLANE_LAST = PLANE_W'(PLANE_COUNT - 1);

   lmbsd_pkg::phase_type phase_ff, phase_in;
   logic [PLANE_W-1:0]   plane_ff, plane_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [LIT_W-1:0]     lit_cnt_ff, lit_cnt_in;
   logic [lmbsd_pkg::ROW_ADDR_W-1:0] row_hold_ff, row_hold_in;

   logic [PROD_W-1:0] prod_ff;
   logic [LIT_W-1:0]  lit_time_ff;
   logic [NUM_W-1:0]  lit_num;
   logic [63:0]       lit_scaled;

   // Lit time: (base << plane) * brightness / 255, two register stages
   assign lit_num    = NUM_W'(prod_ff) << plane_ff;
   assign lit_scaled = 64'(lit_num) * 64'(lmbsd_pkg::DIV255_MAGIC);

   always_ff @(posedge clock) begin
      prod_ff     <= PROD_W'(base_on_ticks) * PROD_W'(brightness);
      lit_time_ff <= LIT_W'(lit_scaled >> lmbsd_pkg::DIV255_SHIFT);
   end

   // Next state of the sequencer
   always_comb begin
      logic row_done;
      row_done    = 1'b0;
      phase_in    = phase_ff;
      plane_in    = plane_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      lit_cnt_in  = lit_cnt_ff;
      row_hold_in = row_hold_ff;
      if (advance) begin
         unique case (phase_ff)
            lmbsd_pkg::PH_DATA: begin
               phase_in = lmbsd_pkg::PH_CLK_HI;
            end
            lmbsd_pkg::PH_CLK_HI: begin
               phase_in = lmbsd_pkg::PH_CLK_LO;
            end
            lmbsd_pkg::PH_CLK_LO: begin
               if (col_ff == COL_LAST) begin
                  col_in   = '0;
                  phase_in = lmbsd_pkg::PH_BLANK;
               end else begin
                  col_in   = col_ff + 1'b1;
                  phase_in = lmbsd_pkg::PH_DATA;
               end
            end
            lmbsd_pkg::PH_BLANK: begin
               row_hold_in = lmbsd_pkg::ROW_ADDR_W'(row_ff);
               phase_in    = lmbsd_pkg::PH_LAT_HI;
            end
            lmbsd_pkg::PH_LAT_HI: begin
               phase_in = lmbsd_pkg::PH_LAT_LO;
            end
            lmbsd_pkg::PH_LAT_LO: begin
               if (lit_time_ff == '0) begin
                  row_done = 1'b1;
               end else begin
                  lit_cnt_in = lit_time_ff;
                  phase_in   = lmbsd_pkg::PH_LIT;
               end
            end
            lmbsd_pkg::PH_LIT: begin
               if (lit_cnt_ff != '0) begin
                  lit_cnt_in = lit_cnt_ff - 1'b1;
               end
               if (lit_cnt_in == '0) begin
                  row_done = 1'b1;
               end
            end
            default: begin
               row_done = 1'b1;
            end
         endcase
         // Move on to the next row pair, and plane at the last one
         if (row_done) begin
            phase_in = lmbsd_pkg::PH_DATA;
            col_in   = '0;
            if (row_ff == ROW_LAST) begin
               row_in   = '0;
               plane_in = (plane_ff == PLANE_LAST) ? '0 : plane_ff + 1'b1;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
      end
   end

   // Pin controls of the current tick
   always_comb begin
      ctrl             = '0;
      ctrl.blank_n     = 1'b1;
      ctrl.frame_start = (plane_ff == '0) && (row_ff == '0) && (col_ff == '0) &&
                         (phase_ff == lmbsd_pkg::PH_DATA);
      ctrl.row_address = (phase_ff == lmbsd_pkg::PH_BLANK) ?
                         lmbsd_pkg::ROW_ADDR_W'(row_ff) : row_hold_ff;
      ctrl.bit_sel     = lmbsd_pkg::BIT_SEL_W'(BIT_BASE) +
                         lmbsd_pkg::BIT_SEL_W'(plane_ff);
      unique case (phase_ff)
         lmbsd_pkg::PH_DATA: begin
            ctrl.data_en = 1'b1;
         end
         lmbsd_pkg::PH_CLK_HI: begin
            ctrl.data_en     = 1'b1;
            ctrl.shift_clock = 1'b1;
         end
         lmbsd_pkg::PH_CLK_LO: begin
            ctrl.data_en = 1'b1;
         end
         lmbsd_pkg::PH_LAT_HI: begin
            ctrl.latch = 1'b1;
         end
         lmbsd_pkg::PH_LIT: begin
            ctrl.blank_n = 1'b0;
         end
         default: begin
            ctrl.data_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= lmbsd_pkg::PH_DATA;
         plane_ff    <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         lit_cnt_ff  <= '0;
         row_hold_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         plane_ff    <= plane_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         lit_cnt_ff  <= lit_cnt_in;
         row_hold_ff <= row_hold_in;
      end
   end

   assign cur_row = row_ff;
   assign cur_col = col_ff;

endmodule

@@ design/led_matrix_bcm_scan_driver.sv @@
// ----------------------------------------------------------------------------
// led_matrix_bcm_scan_driver
// Dual-scan RGB LED matrix driver with binary code modulation.
// ----------------------------------------------------------------------------
// Each tick request returns one pin vector, and ticks may be sent every cycle
// unless a sweep or register write holds requests off or the pin vectors
// stall; the sequencer steps at the transfer while both frame-buffer halves
// are read in the same cycle, and the output stage registers the result.
// Pixel writes go straight into the buffer and give no response. After reset
// and after each clear request the buffer is swept to black, one word per half
// per cycle, holding requests off until all PANEL_COLUMNS * SCAN_ROW_PAIRS
// words (1024 by default) are black. A register write holds requests off
// while the lit-time multiplier pipeline takes up the new value. Register
// writes are taken at any time but must be made only while the block is idle.
// ----------------------------------------------------------------------------
module led_matrix_bcm_scan_driver #(
   parameter int PANEL_COLUMNS  = lmbsd_pkg::DEF_PANEL_COLUMNS,
   parameter int SCAN_ROW_PAIRS = lmbsd_pkg::DEF_SCAN_ROW_PAIRS,
   parameter int PLANE_COUNT    = lmbsd_pkg::DEF_PLANE_COUNT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Requests
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pixel_x[5:0], pixel_y[10:6], red_level[18:11], green_level[26:19],
   // blue_level[34:27], zero[39:35]
   input  logic [lmbsd_pkg::REQ_DATA_W-1:0]    req_tdata,
   // mode[1:0]
   input  logic [lmbsd_pkg::MODE_W-1:0]        req_tuser,
   // Pin vectors
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // top_red[0], top_green[1], top_blue[2], bottom_red[3], bottom_green[4],
   // bottom_blue[5], shift_clock[6], latch[7], blank_n[8],
   // row_address[13:9], frame_start[14], zero[15]
   output logic [lmbsd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // Register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lmbsd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lmbsd_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int COL_W = $clog2(PANEL_COLUMNS);
   localparam int ROW_W = $clog2(SCAN_ROW_PAIRS);

   // Request fields
   lmbsd_pkg::mode_type                 req_mode;
   logic [lmbsd_pkg::PIXEL_X_W-1:0]     req_x;
   logic [lmbsd_pkg::PIXEL_Y_W-1:0]     req_y;
   logic [lmbsd_pkg::RGB_W-1:0]         req_rgb;
   logic                                req_fire, tick_fire, write_fire, clear_fire;
   logic                                csr_fire;

   // Registers
   logic [lmbsd_pkg::BRIGHT_W-1:0] brightness_ff;
   logic [lmbsd_pkg::BASE_W-1:0]   base_ff;
   logic                           swap_ff;
   logic [1:0]                     settle_ff, settle_in;

   // Pipeline
   logic                           s1_valid_ff;
   lmbsd_pkg::scan_ctrl_type       s1_ctrl_ff;
   logic                           s1_move;
   logic                           out_valid_ff;
   logic [lmbsd_pkg::RSP_DATA_W-1:0] out_data_ff, out_data_in;

   lmbsd_pkg::scan_ctrl_type       seq_ctrl;
   logic [ROW_W-1:0]               cur_row;
   logic [COL_W-1:0]               cur_col;
   logic [lmbsd_pkg::RGB_W-1:0]    top_rgb, bot_rgb;
   logic                           store_busy;

   // Unpack the request
   assign req_mode = lmbsd_pkg::mode_type'(req_tuser);
   assign req_x    = req_tdata[5:0];
   assign req_y    = req_tdata[10:6];
   assign req_rgb  = {req_tdata[18:11], req_tdata[26:19], req_tdata[34:27]};

   // Accept a request once buffer and lit time are ready and stage one can drain
   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !store_busy && (settle_ff == '0) && (!s1_valid_ff || s1_move);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      tick_fire  = 1'b0;
      write_fire = 1'b0;
      clear_fire = 1'b0;
      unique case (req_mode)
         lmbsd_pkg::MODE_TICK:  tick_fire  = req_fire;
         lmbsd_pkg::MODE_WRITE: write_fire = req_fire;
         lmbsd_pkg::MODE_CLEAR: clear_fire = req_fire;
         default:               tick_fire  = 1'b0;
      endcase
   end

   // Register writes
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= lmbsd_pkg::BRIGHT_RESET;
         base_ff       <= lmbsd_pkg::BASE_RESET;
         swap_ff       <= 1'b0;
      end else if (csr_fire) begin
         unique case (lmbsd_pkg::csr_index_type'(csr_index))
            lmbsd_pkg::CSR_BRIGHTNESS: brightness_ff <= csr_data[7:0];
            lmbsd_pkg::CSR_BASE_TICKS: base_ff       <= csr_data;
            lmbsd_pkg::CSR_SWAP_GB:    swap_ff       <= csr_data[0];
            default:                   swap_ff       <= swap_ff;
         endcase
      end
   end

   // Hold requests off until the lit-time pipeline has caught up
   always_comb begin
      settle_in = settle_ff;
      if (csr_fire) begin
         settle_in = lmbsd_pkg::SETTLE_CYCLES;
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= '0;
      end else begin
         settle_ff <= settle_in;
      end
   end

   lmbsd_frame_store #(
      .PANEL_COLUMNS  (PANEL_COLUMNS),
      .SCAN_ROW_PAIRS (SCAN_ROW_PAIRS)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .clear_start (clear_fire),
      .rd_en       (tick_fire),
      .rd_row      (cur_row),
      .rd_col      (cur_col),
      .wr_en       (write_fire),
      .wr_x        (req_x),
      .wr_y        (req_y),
      .wr_rgb      (req_rgb),
      .top_rgb     (top_rgb),
      .bot_rgb     (bot_rgb),
      .busy        (store_busy)
   );

   lmbsd_scan_seq #(
      .PANEL_COLUMNS  (PANEL_COLUMNS),
      .SCAN_ROW_PAIRS (SCAN_ROW_PAIRS),
      .PLANE_COUNT    (PLANE_COUNT)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .advance       (tick_fire),
      .brightness    (brightness_ff),
      .base_on_ticks (base_ff),
      .cur_row       (cur_row),
      .cur_col       (cur_col),
      .ctrl          (seq_ctrl)
   );

   // Stage one: hold the tick controls beside the buffer read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (tick_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_fire) begin
         s1_ctrl_ff <= seq_ctrl;
      end
   end

   // Pick the plane bit of each colour and assemble the pin vector
   always_comb begin
      logic [lmbsd_pkg::LEVEL_W-1:0] tr, tg, tb, br, bg, bb;
      logic                          b_tr, b_tg, b_tb, b_br, b_bg, b_bb;
      tr   = top_rgb[23:16];
      tg   = top_rgb[15:8];
      tb   = top_rgb[7:0];
      br   = bot_rgb[23:16];
      bg   = bot_rgb[15:8];
      bb   = bot_rgb[7:0];
      b_tr = s1_ctrl_ff.data_en && tr[s1_ctrl_ff.bit_sel];
      b_tg = s1_ctrl_ff.data_en && tg[s1_ctrl_ff.bit_sel];
      b_tb = s1_ctrl_ff.data_en && tb[s1_ctrl_ff.bit_sel];
      b_br = s1_ctrl_ff.data_en && br[s1_ctrl_ff.bit_sel];
      b_bg = s1_ctrl_ff.data_en && bg[s1_ctrl_ff.bit_sel];
      b_bb = s1_ctrl_ff.data_en && bb[s1_ctrl_ff.bit_sel];
      out_data_in = {1'b0,
                     s1_ctrl_ff.frame_start,
                     s1_ctrl_ff.row_address,
                     s1_ctrl_ff.blank_n,
                     s1_ctrl_ff.latch,
                     s1_ctrl_ff.shift_clock,
                     swap_ff ? b_bg : b_bb,
                     swap_ff ? b_bb : b_bg,
                     b_br,
                     swap_ff ? b_tg : b_tb,
                     swap_ff ? b_tb : b_tg,
                     b_tr};
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

@@ design/lmbsd_checker.sv @@
// ----------------------------------------------------------------------------
// lmbsd_checker
// Port-level checks of the scan driver, bound to the top level.
// ----------------------------------------------------------------------------
module lmbsd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [lmbsd_pkg::MODE_W-1:0]      req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [lmbsd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                              csr_valid,
   input logic                              csr_ready
);

   logic tick_xfer, clear_xfer;

   assign tick_xfer  = req_tvalid && req_tready &&
                       (req_tuser == lmbsd_pkg::MODE_TICK);
   assign clear_xfer = req_tvalid && req_tready &&
                       (req_tuser == lmbsd_pkg::MODE_CLEAR);

   // A stalled pin vector holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("pin vector changed while stalled");

   // A fresh pin vector follows a tick, via stage one and the output register
   a_rsp_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(tick_xfer, 2))
      else $error("pin vector without a tick");

   // A clear starts the sweep and blocks requests
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clear_xfer |=> !req_tready)
      else $error("request taken during clearing sweep");

   // A register write holds requests off while the lit time settles
   a_csr_settle: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_tready)
      else $error("request taken right after register write");

   // Reset starts the clearing sweep
   a_reset_sweep: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken right after reset");

endmodule

bind led_matrix_bcm_scan_driver lmbsd_checker u_lmbsd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LED matrix scan driver. Pixel writes, clears,
// unused-mode items and refresh ticks go in over the request stream; every
// tick's pin vector is predicted from a private copy of the frame store, the
// refresh sequencer and the registers, and checked in order of arrival. The
// run walks through several register settings, including some with the lit
// time cut to nothing, and stalls both streams at random.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int COLS            = lmbsd_pkg::DEF_PANEL_COLUMNS;
   localparam int PAIRS           = lmbsd_pkg::DEF_SCAN_ROW_PAIRS;
   localparam int PLANES          = lmbsd_pkg::DEF_PLANE_COUNT;
   localparam int STORE_WORDS     = COLS * 2 * PAIRS;
   localparam int FULL_BRIGHTNESS = 255;
   localparam int MISMATCH_SHOWN  = 10;
   localparam int DRAIN_CYCLES    = 8;
   localparam int unsigned RUN_LIMIT = 4_000_000;

   localparam int MODE_W      = lmbsd_pkg::MODE_W;
   localparam int PIXEL_X_W   = lmbsd_pkg::PIXEL_X_W;
   localparam int PIXEL_Y_W   = lmbsd_pkg::PIXEL_Y_W;
   localparam int LEVEL_W     = lmbsd_pkg::LEVEL_W;
   localparam int RGB_W       = lmbsd_pkg::RGB_W;
   localparam int ROW_ADDR_W  = lmbsd_pkg::ROW_ADDR_W;
   localparam int BRIGHT_W    = lmbsd_pkg::BRIGHT_W;
   localparam int BASE_W      = lmbsd_pkg::BASE_W;
   localparam int CSR_INDEX_W = lmbsd_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W  = lmbsd_pkg::CSR_DATA_W;
   localparam int REQ_DATA_W  = lmbsd_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W  = lmbsd_pkg::RSP_DATA_W;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // Pin vector as it travels on rsp_tdata, highest field first
   typedef struct packed {
      logic                  pad;
      logic                  frame_start;
      logic [ROW_ADDR_W-1:0] row_address;
      logic                  blank_n;
      logic                  latch;
      logic                  shift_clock;
      logic                  bottom_blue;
      logic                  bottom_green;
      logic                  bottom_red;
      logic                  top_blue;
      logic                  top_green;
      logic                  top_red;
   } pin_vector_type;

   // Frame store, refresh sequencer and registers, stepped once per transfer
   class bcm_pin_scoreboard_type;
      bit [RGB_W-1:0]       frame_store [STORE_WORDS];
      bit [2:0]             plane_sel;
      bit [4:0]             row_sel;
      bit [6:0]             column_sel;
      lmbsd_pkg::phase_type step_phase;
      bit [20:0]            lit_left;
      bit [ROW_ADDR_W-1:0]  row_hold;
      bit [BRIGHT_W-1:0]    brightness;
      bit [BASE_W-1:0]      base_ticks;
      bit                   swap_gb;
      pin_vector_type       pending_pins [$];
      int unsigned          mismatches;

      function new();
         foreach (frame_store[i]) frame_store[i] = '0;
         plane_sel  = '0;
         row_sel    = '0;
         column_sel = '0;
         step_phase = lmbsd_pkg::PH_DATA;
         lit_left   = '0;
         row_hold   = '0;
         brightness = lmbsd_pkg::BRIGHT_RESET;
         base_ticks = lmbsd_pkg::BASE_RESET;
         swap_gb    = 1'b0;
         mismatches = 0;
      endfunction

      function void set_register(lmbsd_pkg::csr_index_type index,
                                 logic [CSR_DATA_W-1:0] value);
         case (index)
            lmbsd_pkg::CSR_BRIGHTNESS: brightness = value[BRIGHT_W-1:0];
            lmbsd_pkg::CSR_BASE_TICKS: base_ticks = value[BASE_W-1:0];
            lmbsd_pkg::CSR_SWAP_GB:    swap_gb    = value[0];
            default: ;
         endcase
      endfunction

      // Place the current plane's bits of both halves of the current column
      function void put_column_bits(inout pin_vector_type pins);
         bit [RGB_W-1:0] upper;
         bit [RGB_W-1:0] lower;
         int             bit_pos;
         bit_pos = 8 - PLANES + plane_sel;
         upper = frame_store[row_sel * COLS + column_sel];
         lower = frame_store[(row_sel + PAIRS) * COLS + column_sel];
         pins.top_red      = upper[16 + bit_pos];
         pins.top_green    = swap_gb ? upper[bit_pos] : upper[8 + bit_pos];
         pins.top_blue     = swap_gb ? upper[8 + bit_pos] : upper[bit_pos];
         pins.bottom_red   = lower[16 + bit_pos];
         pins.bottom_green = swap_gb ? lower[bit_pos] : lower[8 + bit_pos];
         pins.bottom_blue  = swap_gb ? lower[8 + bit_pos] : lower[bit_pos];
      endfunction

      function void advance_row();
         step_phase = lmbsd_pkg::PH_DATA;
         column_sel = '0;
         if (row_sel == PAIRS - 1) begin
            row_sel = '0;
            plane_sel = (plane_sel == PLANES - 1) ? 3'd0 : plane_sel + 3'd1;
         end else begin
            row_sel = row_sel + 5'd1;
         end
      endfunction

      // One refresh tick: the pins it drives and the sequencer's next state
      function pin_vector_type step_sequencer();
         pin_vector_type    pins;
         longint unsigned   lit_total;
         pins = '0;
         pins.blank_n = 1'b1;
         pins.frame_start = (plane_sel == 0 && row_sel == 0 && column_sel == 0 &&
                             step_phase == lmbsd_pkg::PH_DATA);
         case (step_phase)
            lmbsd_pkg::PH_DATA: begin
               put_column_bits(pins);
               step_phase = lmbsd_pkg::PH_CLK_HI;
            end
            lmbsd_pkg::PH_CLK_HI: begin
               put_column_bits(pins);
               pins.shift_clock = 1'b1;
               step_phase = lmbsd_pkg::PH_CLK_LO;
            end
            lmbsd_pkg::PH_CLK_LO: begin
               put_column_bits(pins);
               column_sel = column_sel + 7'd1;
               step_phase = (column_sel >= COLS) ? lmbsd_pkg::PH_BLANK :
                                                   lmbsd_pkg::PH_DATA;
            end
            lmbsd_pkg::PH_BLANK: begin
               row_hold = row_sel;
               step_phase = lmbsd_pkg::PH_LAT_HI;
            end
            lmbsd_pkg::PH_LAT_HI: begin
               pins.latch = 1'b1;
               step_phase = lmbsd_pkg::PH_LAT_LO;
            end
            lmbsd_pkg::PH_LAT_LO: begin
               // a zero lit time skips straight to the next row pair
               lit_total = ((longint'(base_ticks) << plane_sel) * brightness) /
                           FULL_BRIGHTNESS;
               if (lit_total == 0) begin
                  advance_row();
               end else begin
                  lit_left = 21'(lit_total);
                  step_phase = lmbsd_pkg::PH_LIT;
               end
            end
            lmbsd_pkg::PH_LIT: begin
               pins.blank_n = 1'b0;
               if (lit_left != 0) lit_left = lit_left - 21'd1;
               if (lit_left == 0) advance_row();
            end
            default: advance_row();
         endcase
         pins.row_address = row_hold;
         return pins;
      endfunction

      function void take_request(logic [MODE_W-1:0] mode, logic [PIXEL_X_W-1:0] x,
                                 logic [PIXEL_Y_W-1:0] y, logic [LEVEL_W-1:0] red,
                                 logic [LEVEL_W-1:0] green, logic [LEVEL_W-1:0] blue);
         case (mode)
            lmbsd_pkg::MODE_TICK:  pending_pins.push_back(step_sequencer());
            lmbsd_pkg::MODE_WRITE: frame_store[y * COLS + x] = {red, green, blue};
            lmbsd_pkg::MODE_CLEAR: foreach (frame_store[i]) frame_store[i] = '0;
            default: ; // unused mode leaves everything alone
         endcase
      endfunction

      function string pins_text(pin_vector_type p);
         return $sformatf({"rgb %b%b%b/%b%b%b clk %b lat %b blank_n %b",
                           " row %0d start %b pad %b"},
                          p.top_red, p.top_green, p.top_blue, p.bottom_red,
                          p.bottom_green, p.bottom_blue, p.shift_clock, p.latch,
                          p.blank_n, p.row_address, p.frame_start, p.pad);
      endfunction

      function void check_pins(logic [RSP_DATA_W-1:0] raw);
         pin_vector_type got;
         pin_vector_type want;
         got = raw;
         if (pending_pins.size() == 0) begin
            mismatches++;
            if (mismatches <= MISMATCH_SHOWN)
               $display("unexpected pin vector: %s", pins_text(got));
         end else begin
            want = pending_pins.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MISMATCH_SHOWN)
                  $display("pin vector mismatch\n  expected %s\n  actual   %s",
                           pins_text(want), pins_text(got));
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic [MODE_W-1:0]      req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   bcm_pin_scoreboard_type sb;
   bit                req_throttle;
   bit                rsp_throttle;
   bit                rsp_stalling = 1'b0;
   int unsigned       rsp_run_left = 0;
   int unsigned       cycle_count = 0;

   led_matrix_bcm_scan_driver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mostly short idle stretches, now and then a long one
   function automatic int unsigned gap_length();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [LEVEL_W-1:0] colour_level();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return LEVEL_W'($urandom);
      endcase
   endfunction

   // Alternate ready and stalled runs on the pin vector side
   always @(negedge clock) begin
      logic next_ready;
      next_ready = 1'b1;
      if (rsp_throttle) begin
         if (rsp_run_left == 0) begin
            rsp_stalling = !rsp_stalling;
            rsp_run_left = rsp_stalling ? gap_length() : $urandom_range(1, 20);
         end
         rsp_run_left--;
         next_ready = !rsp_stalling;
      end
      rsp_tready <= next_ready;
   end

   // Check every pin vector transfer
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         sb.check_pins(rsp_tdata);
   end

   // Abort a run that hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Called at a falling edge; returns at a falling edge after the transfer
   task automatic send_request(input logic [MODE_W-1:0] mode, input logic [PIXEL_X_W-1:0] x,
                               input logic [PIXEL_Y_W-1:0] y, input logic [LEVEL_W-1:0] red,
                               input logic [LEVEL_W-1:0] green,
                               input logic [LEVEL_W-1:0] blue);
      int unsigned idle;
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {5'd0, blue, green, red, y, x};
      do @(posedge clock); while (!req_tready);
      sb.take_request(mode, x, y, red, green, blue);
      @(negedge clock);
      // when throttled, now and then drop valid for a random gap before the next item
      idle = 0;
      if (req_throttle && $urandom_range(0, 99) >= 65) idle = gap_length();
      if (idle != 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
   endtask

   // Tick, clear or unused mode, with noise in the ignored fields
   task automatic send_opcode(input logic [MODE_W-1:0] mode);
      send_request(mode, PIXEL_X_W'($urandom), PIXEL_Y_W'($urandom), LEVEL_W'($urandom),
                   LEVEL_W'($urandom), LEVEL_W'($urandom));
   endtask

   // Half the writes land on the row pair and columns about to be shifted
   task automatic send_pixel();
      logic [PIXEL_X_W-1:0] x;
      logic [PIXEL_Y_W-1:0] y;
      x = PIXEL_X_W'($urandom);
      y = PIXEL_Y_W'($urandom);
      if ($urandom_range(0, 1) == 1) begin
         y = PIXEL_Y_W'(sb.row_sel + ($urandom_range(0, 1) * PAIRS));
         x = PIXEL_X_W'(sb.column_sel + $urandom_range(0, 3));
      end
      send_request(lmbsd_pkg::MODE_WRITE, x, y, colour_level(), colour_level(),
                   colour_level());
   endtask

   // Hold requests until every pin vector is in and the pipeline has settled
   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      while (sb.pending_pins.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input lmbsd_pkg::csr_index_type index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(index, value);
      @(negedge clock);
   endtask

   // Write all three registers; unused upper data bits carry noise
   task automatic apply_setting(input logic [BRIGHT_W-1:0] bright,
                                input logic [BASE_W-1:0] base, input logic swap);
      write_register(lmbsd_pkg::CSR_BRIGHTNESS, {8'($urandom), bright});
      write_register(lmbsd_pkg::CSR_BASE_TICKS, base);
      write_register(lmbsd_pkg::CSR_SWAP_GB, {15'($urandom), swap});
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [BRIGHT_W-1:0] bright, input logic [BASE_W-1:0] base,
                            input logic swap, input int unsigned count);
      int unsigned done;
      int unsigned pick;
      wait_until_idle();
      apply_setting(bright, base, swap);
      req_throttle = ($urandom_range(0, 3) != 0);
      rsp_throttle = ($urandom_range(0, 3) != 0);
      done = 0;
      while (done < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) send_opcode(lmbsd_pkg::MODE_TICK);
         else if (pick < 93) send_pixel();
         else if (pick < 95) send_opcode(lmbsd_pkg::MODE_CLEAR);
         else send_opcode(MODE_UNUSED);
         if (pick < 95) done++;
      end
   endtask

   initial begin
      sb = new();
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      req_throttle = 1'b0;
      rsp_throttle = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: corner pixels, colour bits per column, unused mode, clear
      send_opcode(lmbsd_pkg::MODE_TICK);
      send_request(lmbsd_pkg::MODE_WRITE, 6'd0, 5'd0, 8'hFF, 8'hFF, 8'hFF);
      send_request(lmbsd_pkg::MODE_WRITE, 6'd63, 5'd31, 8'hFF, 8'hFF, 8'hFF);
      send_request(lmbsd_pkg::MODE_WRITE, 6'd0, 5'd16, 8'hFF, 8'h00, 8'h00);
      send_request(lmbsd_pkg::MODE_WRITE, 6'd1, 5'd0, 8'h00, 8'hFF, 8'h00);
      send_request(lmbsd_pkg::MODE_WRITE, 6'd1, 5'd16, 8'h00, 8'h00, 8'hFF);
      send_request(MODE_UNUSED, 6'd2, 5'd0, 8'hFF, 8'hFF, 8'hFF);
      send_request(lmbsd_pkg::MODE_WRITE, 6'd2, 5'd0, 8'h04, 8'hFB, 8'h00);
      repeat (9) send_opcode(lmbsd_pkg::MODE_TICK);
      send_opcode(lmbsd_pkg::MODE_CLEAR);
      repeat (3) send_opcode(lmbsd_pkg::MODE_TICK);

      // Random phases across register settings, two with no lit time
      run_phase(8'd255, 16'd1, 1'b0, 250);
      run_phase(8'd0, 16'hFFFF, 1'b1, 150);
      run_phase(8'd1, 16'hFFFF, 1'b0, 150);
      run_phase(8'd128, 16'd3, 1'b1, 150);
      run_phase(8'd255, 16'd0, 1'b0, 100);
      run_phase(8'd255, 16'd2, 1'b1, 150);
      repeat (3)
         run_phase(BRIGHT_W'($urandom_range(1, 255)), BASE_W'($urandom_range(0, 40)),
                   1'($urandom), 80);

      wait_until_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_pins.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ led_matrix_bcm_scan_driver.f @@
design/lmbsd_pkg.sv
design/lmbsd_frame_store.sv
design/lmbsd_scan_seq.sv
design/led_matrix_bcm_scan_driver.sv
design/lmbsd_checker.sv
verif/tb_top.sv
